// ===== sv/bsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_pkg: shared types and constants for the bracket strip and trim filter
// Payload structs, register indexes, bracket codes and the whitespace test.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int DEPTH_MAX_DEF     = 255;
  localparam int PENDING_DEPTH_DEF = 32;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_SQUARE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_ROUND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_ENABLE  = 2'd2;

  localparam logic [7:0] CH_SQ_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_SQ_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CH_RD_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_RD_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       last;
    logic       trim_overflow;
  } rsp_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       keep;
    logic       eos;
  } cmd_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== sv/bsf_front.sv =====
// ----------------------------------------------------------------------------
// bsf_front: bracket tracking front end
// Keeps the two depth counters and marks each byte as kept or dropped.
// ----------------------------------------------------------------------------
module bsf_front #(
  parameter int DEPTH_MAX = bsf_pkg::DEPTH_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          strip_square,
  input  logic          strip_round,
  input  logic          req_valid,
  output logic          req_ready,
  input  bsf_pkg::req_t req_data,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output bsf_pkg::cmd_t cmd
);

  localparam int DW = $clog2(DEPTH_MAX + 1);
  localparam logic [DW-1:0] DMAX = DW'(DEPTH_MAX);

  logic [DW-1:0] square_depth, square_depth_next;
  logic [DW-1:0] round_depth, round_depth_next;
  logic          keep;
  logic [7:0]    c;

  assign c = req_data.char_in;

  always_comb begin
    keep              = 1'b0;
    square_depth_next = square_depth;
    round_depth_next  = round_depth;
    if (strip_square && c == bsf_pkg::CH_SQ_OPEN) begin
      if (square_depth < DMAX) square_depth_next = square_depth + 1'b1;
    end else if (strip_square && c == bsf_pkg::CH_SQ_CLOSE) begin
      if (square_depth != '0) square_depth_next = square_depth - 1'b1;
      else keep = 1'b1;
    end else if (strip_round && c == bsf_pkg::CH_RD_OPEN) begin
      if (round_depth < DMAX) round_depth_next = round_depth + 1'b1;
    end else if (strip_round && c == bsf_pkg::CH_RD_CLOSE) begin
      if (round_depth != '0) round_depth_next = round_depth - 1'b1;
      else keep = 1'b1;
    end else if (square_depth == '0 && round_depth == '0) begin
      keep = 1'b1;
    end
    // string end clears depths
    if (req_data.end_of_string) begin
      square_depth_next = '0;
      round_depth_next  = '0;
    end
  end

  assign req_ready = cmd_ready;
  assign cmd_valid = req_valid;
  assign cmd       = '{ch: c, keep: keep, eos: req_data.end_of_string};

  always_ff @(posedge clk) begin
    if (rst) begin
      square_depth <= '0;
      round_depth  <= '0;
    end else if (req_valid && cmd_ready) begin
      square_depth <= square_depth_next;
      round_depth  <= round_depth_next;
    end
  end

endmodule

// ===== sv/bsf_queue.sv =====
// ----------------------------------------------------------------------------
// bsf_queue: small request queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bsf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bsf_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bsf_pkg::cmd_t rd_data
);

  localparam logic [bsf_pkg::QUEUE_PTR_W-1:0] LAST_SLOT =
    bsf_pkg::QUEUE_PTR_W'(bsf_pkg::QUEUE_DEPTH - 1);
  localparam logic [bsf_pkg::QUEUE_CNT_W-1:0] FULL =
    bsf_pkg::QUEUE_CNT_W'(bsf_pkg::QUEUE_DEPTH);

  bsf_pkg::cmd_t                     slots [bsf_pkg::QUEUE_DEPTH];
  logic [bsf_pkg::QUEUE_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [bsf_pkg::QUEUE_CNT_W-1:0]   count;
  logic                              push, pop;

  assign wr_ready = (count != FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== sv/bsf_back.sv =====
// ----------------------------------------------------------------------------
// bsf_back: trim engine and result register
// Holds pending whitespace in a circular buffer and emits result items.
// ----------------------------------------------------------------------------
module bsf_back #(
  parameter int PENDING_DEPTH = bsf_pkg::PENDING_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          trim_enable,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bsf_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bsf_pkg::rsp_t rsp_data
);

  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(PENDING_DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(PENDING_DEPTH);
  localparam logic [CW-1:0] ONE       = CW'(1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FLUSH, S_OVF} state_t;

  state_t        state, state_next;
  bsf_pkg::cmd_t cur;
  logic          seen_text, seen_text_next;
  logic [PW-1:0] head, head_next, head_inc;
  logic [PW-1:0] tail, tail_next, tail_inc;
  logic [CW-1:0] pending_count, pending_count_next;

  logic [7:0]    pending_space [PENDING_DEPTH];
  logic [7:0]    rd_data;
  logic          rd_en, mem_we;
  logic [PW-1:0] rd_addr;

  logic          out_free, emit, done;
  bsf_pkg::rsp_t emit_val;
  logic          emit_char, pend;

  assign out_free = !rsp_valid || rsp_ready;
  assign head_inc = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + 1'b1;

  assign emit_char = cur.keep && (!trim_enable || !bsf_pkg::is_blank(cur.ch));
  assign pend      = cur.keep && trim_enable && bsf_pkg::is_blank(cur.ch) &&
                     seen_text && !cur.eos;

  always_comb begin
    state_next         = state;
    cmd_ready          = 1'b0;
    emit               = 1'b0;
    emit_val           = '0;
    mem_we             = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = head;
    head_next          = head;
    tail_next          = tail;
    pending_count_next = pending_count;
    seen_text_next     = seen_text;
    done               = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (emit_char) begin
          if (pending_count != '0) begin
            rd_en      = 1'b1;
            state_next = S_FLUSH;
          end else if (out_free) begin
            emit           = 1'b1;
            emit_val       = '{char_out: cur.ch, has_char: 1'b1, last: cur.eos,
                               trim_overflow: 1'b0};
            seen_text_next = 1'b1;
            done           = 1'b1;
          end
        end else if (pend) begin
          if (pending_count == FULL) begin
            rd_en      = 1'b1;
            state_next = S_OVF;
          end else begin
            mem_we             = 1'b1;
            tail_next          = tail_inc;
            pending_count_next = pending_count + ONE;
            state_next         = S_IDLE;
          end
        end else if (cur.eos) begin
          // nothing emitted: bare end marker
          if (out_free) begin
            emit     = 1'b1;
            emit_val = '{char_out: 8'h00, has_char: 1'b0, last: 1'b1,
                         trim_overflow: 1'b0};
            done     = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_val           = '{char_out: rd_data, has_char: 1'b1, last: 1'b0,
                                 trim_overflow: 1'b0};
          head_next          = head_inc;
          pending_count_next = pending_count - ONE;
          if (pending_count != ONE) begin
            rd_en   = 1'b1;
            rd_addr = head_inc;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_OVF: begin
        // buffer full: tail equals head, new byte takes the oldest slot
        if (out_free) begin
          emit       = 1'b1;
          emit_val   = '{char_out: rd_data, has_char: 1'b1, last: 1'b0,
                         trim_overflow: 1'b1};
          mem_we     = 1'b1;
          head_next  = head_inc;
          tail_next  = tail_inc;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (done) begin
      state_next = S_IDLE;
      if (cur.eos) begin
        seen_text_next     = 1'b0;
        pending_count_next = '0;
        head_next          = tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pending_space[tail] <= cur.ch;
    if (rd_en)  rd_data <= pending_space[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seen_text     <= 1'b0;
      head          <= '0;
      tail          <= '0;
      pending_count <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      seen_text     <= seen_text_next;
      head          <= head_next;
      tail          <= tail_next;
      pending_count <= pending_count_next;
      if (emit)           rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
    if (state == S_IDLE && cmd_valid) cur <= cmd;
    if (emit) rsp_data <= emit_val;
  end

endmodule

// ===== sv/bracket_strip_and_trim_filter.sv =====
// Flow: the front end passes each request straight into the queue; the back end
//   pops one, executes it, and takes the next only when it is done, after any
//   flush of pending bytes, overflow release or stalled result.
// Reset (rst, synchronous): clears depths, trim state, queue and result valid;
//   configuration registers return to 1. Pending buffer contents are not cleared.
// ----------------------------------------------------------------------------
// bracket_strip_and_trim_filter: top level
// Front end tracks bracket depths, a two-entry queue decouples it from the
// back end, which trims whitespace and drives the result register.
// ----------------------------------------------------------------------------
module bracket_strip_and_trim_filter #(
  parameter int DEPTH_MAX     = bsf_pkg::DEPTH_MAX_DEF,
  parameter int PENDING_DEPTH = bsf_pkg::PENDING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_ready,
  input  bsf_pkg::req_t                  req_data,
  // result channel
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output bsf_pkg::rsp_t                  rsp_data,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                           cfg_data
);

  logic          strip_square, strip_round, trim_enable;
  logic          f_valid, f_ready;
  bsf_pkg::cmd_t f_cmd;
  logic          b_valid, b_ready;
  bsf_pkg::cmd_t b_cmd;

  // Config is only to be written while idle (the block does not enforce this), so no ordering against requests.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_square <= 1'b1;
      strip_round  <= 1'b1;
      trim_enable  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsf_pkg::REG_STRIP_SQUARE: strip_square <= cfg_data;
        bsf_pkg::REG_STRIP_ROUND:  strip_round  <= cfg_data;
        bsf_pkg::REG_TRIM_ENABLE:  trim_enable  <= cfg_data;
        default: ;  // unmapped index: write ignored
      endcase
    end
  end

  // Front: depth counters, keep/drop decision per byte.
  bsf_front #(.DEPTH_MAX(DEPTH_MAX)) u_front (
    .clk          (clk),
    .rst          (rst),
    .strip_square (strip_square),
    .strip_round  (strip_round),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_data     (req_data),
    .cmd_valid    (f_valid),
    .cmd_ready    (f_ready),
    .cmd          (f_cmd)
  );

  // Queue: lets the front keep accepting while the back flushes.
  bsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_cmd)
  );

  // Back: pending whitespace buffer, end marker, result register.
  bsf_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .trim_enable (trim_enable),
    .cmd_valid   (b_valid),
    .cmd_ready   (b_ready),
    .cmd         (b_cmd),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data)
  );

endmodule

// ===== sv/bsf_checker.sv =====
// ----------------------------------------------------------------------------
// bsf_checker: port-level checks for the filter
// Watches the result channel and reset behavior.
// ----------------------------------------------------------------------------
module bsf_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bsf_pkg::rsp_t rsp_data
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // bare marker is always the end of a string and carries nothing
  a_bare_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.has_char |->
      rsp_data.last && rsp_data.char_out == 8'h00 && !rsp_data.trim_overflow)
    else $error("bad bare end marker");

  // overflow release is a real byte and never the last one
  a_ovf_mid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.trim_overflow |-> rsp_data.has_char && !rsp_data.last)
    else $error("overflow flag on wrong result");

endmodule

bind bracket_strip_and_trim_filter bsf_checker u_bsf_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for bracket_strip_and_trim_filter
// Directed and random strings go in over the request channel. A predictor
// works out the results of each accepted byte. A checker compares every
// accepted result, field by field, against the oldest expected result.
// Both sides pace at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE      = bsf_pkg::PENDING_DEPTH_DEF + 8;  // longest flush plus pipeline
  localparam int QUIET_LIMIT = 2000;  // cycles without any handshake
  localparam int HOLD_LONG   = 300;   // receiver hold-off for the pressure test
  localparam int RANDOM_REQS = 30;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_ready;
  bsf_pkg::req_t                 req_data  = '0;
  logic                          rsp_valid;
  logic                          rsp_ready = 1'b0;
  bsf_pkg::rsp_t                 rsp_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bsf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic                          cfg_data  = 1'b0;

  bracket_strip_and_trim_filter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter mirror: register copies and string state, all at reset values.
  // --------------------------------------------------------------------------
  bit         strip_sq_on = 1'b1;
  bit         strip_rd_on = 1'b1;
  bit         trim_on     = 1'b1;
  int         sq_level    = 0;
  int         rd_level    = 0;
  bit         text_seen   = 1'b0;
  logic [7:0] held_blanks[$];   // interior whitespace waiting for the next kept byte

  bsf_pkg::rsp_t want_results[$];  // expected results, oldest first
  logic [7:0]    text_buf[$];      // string being assembled for sending

  int errors      = 0;
  int items_sent  = 0;
  int hold_cycles = 0;    // set by a test to ask the receiver for a long hold-off
  bit calm        = 1'b0; // no idling on either side

  // space, tab, LF, VT, FF, CR
  function automatic bit is_space_byte(input logic [7:0] c);
    case (c) inside
      [8'h09:8'h0D], 8'h20: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] blank_byte(input int sel);
    case (sel % 6)
      0: return bsf_pkg::CH_SPACE;
      1: return bsf_pkg::CH_TAB;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return bsf_pkg::CH_CR;
    endcase
  endfunction

  function automatic void add_text(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  // Works out the results caused by one accepted request and queues them.
  // Each emitted entry is {has_char, trim_overflow, byte}.
  function automatic void filter_predict(input bsf_pkg::req_t r);
    logic [9:0]    emit[$];
    logic [7:0]    c;
    logic          pass;
    bsf_pkg::rsp_t res;
    c    = r.char_in;
    pass = 1'b0;

    // bracket tracking; an unmatched closer is kept even inside the other kind
    if (strip_sq_on && c == bsf_pkg::CH_SQ_OPEN) begin
      if (sq_level < bsf_pkg::DEPTH_MAX_DEF) sq_level++;
    end else if (strip_sq_on && c == bsf_pkg::CH_SQ_CLOSE) begin
      if (sq_level > 0) sq_level--;
      else pass = 1'b1;
    end else if (strip_rd_on && c == bsf_pkg::CH_RD_OPEN) begin
      if (rd_level < bsf_pkg::DEPTH_MAX_DEF) rd_level++;
    end else if (strip_rd_on && c == bsf_pkg::CH_RD_CLOSE) begin
      if (rd_level > 0) rd_level--;
      else pass = 1'b1;
    end else if (sq_level == 0 && rd_level == 0) begin
      pass = 1'b1;
    end

    if (pass) begin
      if (!trim_on || !is_space_byte(c)) begin
        foreach (held_blanks[i]) emit.insert(emit.size(), {2'b10, held_blanks[i]});
        held_blanks.delete();
        emit.insert(emit.size(), {2'b10, c});
        text_seen = 1'b1;
      end else if (text_seen && !r.end_of_string) begin
        // full buffer: oldest byte goes out early, flagged
        if (held_blanks.size() >= bsf_pkg::PENDING_DEPTH_DEF)
          emit.insert(emit.size(), {2'b11, held_blanks.pop_front()});
        held_blanks.insert(held_blanks.size(), c);
      end
    end

    // string end always yields one last result, bare if nothing else went out
    if (r.end_of_string && emit.size() == 0) emit.insert(0, 10'h000);
    foreach (emit[i]) begin
      res.char_out      = emit[i][7:0];
      res.trim_overflow = emit[i][8];
      res.has_char      = emit[i][9];
      res.last          = r.end_of_string && (i == emit.size() - 1);
      want_results.insert(want_results.size(), res);
    end

    if (r.end_of_string) begin
      sq_level  = 0;
      rd_level  = 0;
      text_seen = 1'b0;
      held_blanks.delete();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Pacing
  // --------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  initial begin : rsp_pacing
    int n;
    forever begin
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        rsp_ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    bsf_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (want_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %02h/%b/%b/%b",
                 $time, rsp_data.char_out, rsp_data.has_char, rsp_data.last,
                 rsp_data.trim_overflow);
        errors++;
      end else begin
        want = want_results.pop_front();
        check_field("char_out", want.char_out, rsp_data.char_out);
        check_field("has_char", want.has_char, rsp_data.has_char);
        check_field("last", want.last, rsp_data.last);
        check_field("trim_overflow", want.trim_overflow, rsp_data.trim_overflow);
      end
    end
  end

  // Ends the run if no channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog: no handshake for %0d cycles, %0d results outstanding",
             $time, quiet, want_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Valid is left high after acceptance so a back-to-back request does not
  // lower and raise it in one step; a gap or a drain lowers it.
  task automatic send_char(input logic [7:0] c, input logic eos);
    bsf_pkg::req_t r;
    int            gap;
    r.char_in       = c;
    r.end_of_string = eos;
    gap             = sender_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_data  <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    filter_predict(r);
    items_sent++;
  endtask

  task automatic send_text(input bit terminate);
    foreach (text_buf[i])
      send_char(text_buf[i], terminate && (i == text_buf.size() - 1));
  endtask

  task automatic send_str(input string s, input bit terminate);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) add_text(s[i]);
    send_text(terminate);
  endtask

  // Stop sending, wait for every expected result, then let any request that
  // causes no result work its way through.
  task automatic quiesce();
    req_valid <= 1'b0;
    while (want_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all three registers back to back, only once the block is idle.
  task automatic write_config(input bit sq, input bit rd, input bit trim);
    logic [bsf_pkg::CFG_IDX_W-1:0] idx[3];
    bit                            val[3];
    idx[0] = bsf_pkg::REG_STRIP_SQUARE;
    idx[1] = bsf_pkg::REG_STRIP_ROUND;
    idx[2] = bsf_pkg::REG_TRIM_ENABLE;
    val[0] = sq;
    val[1] = rd;
    val[2] = trim;
    quiesce();
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        bsf_pkg::REG_STRIP_SQUARE: strip_sq_on = val[i];
        bsf_pkg::REG_STRIP_ROUND:  strip_rd_on = val[i];
        bsf_pkg::REG_TRIM_ENABLE:  trim_on     = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Word-like random text: printable runs, whitespace runs, bracket groups,
  // stray brackets and the odd raw byte.
  function automatic void build_random_text(input int tokens);
    int         pick;
    logic [7:0] opener;
    logic [7:0] closer;
    text_buf.delete();
    repeat (tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 4)) add_text(8'($urandom_range(8'h21, 8'h7E)));
      end else if (pick < 55) begin
        repeat ($urandom_range(1, 5)) add_text(blank_byte($urandom_range(0, 5)));
      end else if (pick < 75) begin
        opener = $urandom_range(0, 1) ? bsf_pkg::CH_RD_OPEN : bsf_pkg::CH_SQ_OPEN;
        closer = (opener == bsf_pkg::CH_RD_OPEN) ? bsf_pkg::CH_RD_CLOSE
                                                 : bsf_pkg::CH_SQ_CLOSE;
        add_text(opener);
        repeat ($urandom_range(0, 3)) add_text(8'($urandom_range(8'h20, 8'h7E)));
        if ($urandom_range(0, 4) != 0) add_text(closer);
      end else if (pick < 88) begin
        case ($urandom_range(0, 3))
          0: add_text(bsf_pkg::CH_SQ_OPEN);
          1: add_text(bsf_pkg::CH_SQ_CLOSE);
          2: add_text(bsf_pkg::CH_RD_OPEN);
          default: add_text(bsf_pkg::CH_RD_CLOSE);
        endcase
      end else begin
        add_text(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // leading blanks dropped, brackets removed, trailing blank dropped
    send_str(" \t a[b]c(d) ", 1'b1);
    // nested kinds; the final ')' has no opener and is kept
    send_str("[(])x)", 1'b1);
    // ']' with no opener is kept while inside parentheses
    send_str("(]a)", 1'b1);
    // nothing kept: bare end marker
    send_str("[", 1'b1);
    // byte extremes, VT/FF held then released, whitespace on the final byte
    send_char(8'h00, 1'b0);
    send_char(8'h0B, 1'b0);
    send_char(8'h0C, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h0A, 1'b1);
    quiesce();
  endtask

  task automatic test_overflow();
    // one early release, then a full buffer flushes ahead of 'b': largest burst
    send_char("a", 1'b0);
    for (int i = 0; i < bsf_pkg::PENDING_DEPTH_DEF + 1; i++) send_char(blank_byte(i), 1'b0);
    send_char("b", 1'b1);
    // overflow, then the string ends in whitespace and the rest is dropped
    send_char("y", 1'b0);
    for (int i = 0; i < bsf_pkg::PENDING_DEPTH_DEF + 2; i++)
      send_char(blank_byte(i), i == bsf_pkg::PENDING_DEPTH_DEF + 1);
    quiesce();
  endtask

  task automatic test_nesting();
    // two levels of each kind; text inside either kind is dropped
    send_str("k[[((z]]z))m])", 1'b1);
    quiesce();
  endtask

  task automatic test_config_sweep();
    for (int k = 0; k < 8; k++) begin
      write_config(k[0], k[1], k[2]);
      build_random_text($urandom_range(1, 3));
      send_text(1'b1);
    end
    quiesce();
  endtask

  // register changes in the middle of a string
  task automatic test_midstring_config();
    write_config(1'b1, 1'b1, 1'b1);
    send_str("ab \t", 1'b0);
    write_config(1'b1, 1'b1, 1'b0);   // held blanks go out ahead of 'c'
    send_str("c", 1'b1);
    send_str("  d ", 1'b0);
    write_config(1'b1, 1'b1, 1'b1);
    send_str(" e ", 1'b1);
    send_str("f  ", 1'b0);
    write_config(1'b1, 1'b1, 1'b0);   // nothing kept: held blanks discarded at the end
    send_str("[g]", 1'b1);
    write_config(1'b1, 1'b1, 1'b1);
    send_str("[h", 1'b0);
    write_config(1'b0, 1'b1, 1'b1);   // ']' now ordinary, but depth is still set
    send_str("]i", 1'b1);
    write_config(1'b1, 1'b1, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    quiesce();
    calm        = 1'b1;
    hold_cycles = HOLD_LONG;
    text_buf.delete();
    repeat (20) add_text(8'($urandom_range(8'h61, 8'h7A)));
    send_text(1'b1);
    calm = 1'b0;
    quiesce();
  endtask

  task automatic test_random();
    int target;
    target = items_sent + RANDOM_REQS;
    while (items_sent < target) begin
      write_config($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                   $urandom_range(0, 3) != 0);
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 2)) begin
        build_random_text($urandom_range(1, 6));
        send_text(1'b1);
      end
      // sometimes leave a string open across the next register write
      if ($urandom_range(0, 1)) begin
        build_random_text($urandom_range(1, 2));
        send_text(1'b0);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_overflow();
    test_nesting();
    test_config_sweep();
    test_midstring_config();
    test_backpressure();
    test_random();

    // final drain, bounded so leftovers are reported rather than hung on
    req_valid <= 1'b0;
    for (int w = 0; w < QUIET_LIMIT / 2 && want_results.size() != 0; w++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (want_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, want_results.size());
      errors++;
    end
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
